>>> rtl/display_feed_fifo_defines.svh
// Assertion helpers for display_feed_fifo; all sample on clk and mute in reset.
`ifndef DISPLAY_FEED_FIFO_DEFINES_SVH
`define DISPLAY_FEED_FIFO_DEFINES_SVH

// Invariant that holds at every edge out of reset
`define DFF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define DFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dff_pkg.sv
package dff_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH   = 256;
  localparam int PACKET_BYTES = 128;
  localparam int ADDR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 2;
  localparam int FILL_W  = 9;
  localparam int MULT_W  = 3;
  localparam int STEP_W  = 19;
  localparam int BASE_W  = 16;
  localparam int IDLE_W  = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OP_W-1:0] OP_EOP      = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
  localparam logic [OP_W-1:0] OP_MULT_UP  = 3'd3;
  localparam logic [OP_W-1:0] OP_MULT_DN  = 3'd4;

  // Blink codes
  localparam logic [MODE_W-1:0] BLINK_STEADY = 2'd0;
  localparam logic [MODE_W-1:0] BLINK_SLOW   = 2'd1;
  localparam logic [MODE_W-1:0] BLINK_FAST   = 2'd2;

  // Register select (address bit 2)
  localparam logic REG_BASE_PERIOD  = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  // Constants
  localparam logic [CHAR_W-1:0] DASH_CHAR        = 8'd45;
  localparam logic [MULT_W-1:0] MULT_MAX         = 3'd5;
  localparam logic [MULT_W-1:0] MULT_MIN         = 3'd1;
  localparam logic [BASE_W-1:0] BASE_PERIOD_RST  = 16'd1000;
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 32'd20000;

  // Result held between accept and the output register
  typedef struct packed {
    logic              shown_valid;
    logic [MODE_W-1:0] blink_mode;
    logic              has_room;
    logic [FILL_W-1:0] fill_level;
    logic              dropped;
    logic              pop;
    logic              fwd_dash;
  } stage_t;

  // Result as presented on the output channel
  typedef struct packed {
    logic              shown_valid;
    logic [CHAR_W-1:0] shown_char;
    logic [MODE_W-1:0] blink_mode;
    logic              has_room;
    logic [FILL_W-1:0] fill_level;
    logic              dropped;
  } result_t;

endpackage

>>> rtl/dff_ifs.sv
interface dff_in_if import dff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] data_byte;

  modport source (output valid, op, data_byte, input ready);
  modport sink (input valid, op, data_byte, output ready);
endinterface

interface dff_out_if import dff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              shown_valid;
  logic [CHAR_W-1:0] shown_char;
  logic [MODE_W-1:0] blink_mode;
  logic              has_room;
  logic [FILL_W-1:0] fill_level;
  logic              dropped;

  modport source (output valid, shown_valid, shown_char, blink_mode, has_room, fill_level,
                  dropped, input ready);
  modport sink (input valid, shown_valid, shown_char, blink_mode, has_room, fill_level,
                dropped, output ready);
endinterface

>>> rtl/dff_ram.sv
module dff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/display_feed_fifo.sv
// An accepted item's result is registered in the middle stage, then in the output register.
// Throughput: one item per cycle unless out_ch stalls; the character RAM takes one write and
// one read per cycle. The pop read lands in the middle stage; a stall on out_ch holds in_ch
// only once both stages are full. Reset (rst_n low at a clock edge) clears indices, count,
// flags, counters and valid bits, sets config, multiplier and shown-char defaults; payload
// registers and the character RAM are not cleared; the fill count marks the entries in use.
`include "display_feed_fifo_defines.svh"

module display_feed_fifo import dff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dff_in_if.sink            in_ch,
  dff_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // State registers
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              marker_r, marker_nxt;
  logic              fast_r, fast_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic              running_r, running_nxt;
  logic [CHAR_W-1:0] cur_char_r, cur_char_nxt;
  logic [BASE_W-1:0] base_period_r;
  logic [IDLE_W-1:0] idle_timeout_r;

  // Pipeline registers
  logic    p1_valid_r, p1_valid_nxt;
  stage_t  p1_r, p1_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  // Datapath
  logic              accept, p1_go;
  logic [STEP_W-1:0] period, step_inc;
  logic [IDLE_W-1:0] idle_inc;
  logic              tick, disp, full, byte_put, drop, marker_put, pop, expire;
  logic [CNT_W-1:0]  count_m;
  logic [MODE_W-1:0] mode;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;
  logic              cfg_wr;

  dff_ram #(.WIDTH(CHAR_W), .DEPTH(FIFO_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Handshakes
  assign p1_go        = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !p1_valid_r || p1_go;
  assign accept       = in_ch.valid && in_ch.ready;

  // Display step timing
  assign period   = STEP_W'(base_period_r) * STEP_W'(mult_r);
  assign step_inc = step_r + STEP_W'(1);
  assign idle_inc = (running_r && (idle_r != '1)) ? idle_r + IDLE_W'(1) : idle_r;
  assign tick     = (in_ch.op == OP_TICK);
  assign disp     = tick && (step_inc >= period);

  // FIFO moves
  assign full       = (count_r == CNT_W'(FIFO_DEPTH));
  assign byte_put   = (in_ch.op == OP_PUSH) && !full;
  assign drop       = (in_ch.op == OP_PUSH) && full;
  assign marker_put = disp && marker_r && !full;
  assign count_m    = count_r + CNT_W'(marker_put);
  assign pop        = disp && (count_m != '0);
  assign expire     = running_r && (idle_inc >= idle_timeout_r);

  // Blink choice of this step
  always_comb begin
    if (!disp || pop) begin
      mode = BLINK_STEADY;
    end else if (expire || fast_r) begin
      mode = BLINK_FAST;
    end else begin
      mode = BLINK_SLOW;
    end
  end

  // Character RAM access
  assign ram_we    = accept && (byte_put || marker_put);
  assign ram_wdata = byte_put ? in_ch.data_byte : DASH_CHAR;
  assign ram_re    = accept && pop;

  // Next control state on a transfer in
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    count_nxt   = count_m - CNT_W'(pop) + CNT_W'(byte_put);
    marker_nxt  = marker_r;
    fast_nxt    = fast_r;
    mult_nxt    = mult_r;
    step_nxt    = step_r;
    idle_nxt    = idle_r;
    running_nxt = running_r;
    if (byte_put || marker_put) begin
      wr_idx_nxt = (wr_idx_r == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : wr_idx_r + ADDR_W'(1);
    end
    if (pop) begin
      rd_idx_nxt = (rd_idx_r == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : rd_idx_r + ADDR_W'(1);
    end
    case (in_ch.op)
      OP_EOP: begin
        marker_nxt = 1'b1;
      end
      OP_TICK: begin
        idle_nxt = idle_inc;
        step_nxt = disp ? '0 : step_inc;
        if (marker_put) begin
          marker_nxt = 1'b0;
        end
        if (pop) begin
          fast_nxt    = 1'b0;
          idle_nxt    = '0;
          running_nxt = 1'b1;
        end else if (disp && (mode == BLINK_FAST)) begin
          fast_nxt = 1'b1;
        end
      end
      OP_MULT_UP: begin
        if (mult_r < MULT_MAX) begin
          mult_nxt = mult_r + MULT_W'(1);
          step_nxt = '0;
        end
      end
      OP_MULT_DN: begin
        if (mult_r > MULT_MIN) begin
          mult_nxt = mult_r - MULT_W'(1);
          step_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Middle stage: everything but the popped character
  always_comb begin
    p1_nxt.shown_valid = disp;
    p1_nxt.blink_mode  = mode;
    p1_nxt.has_room    = (count_nxt <= CNT_W'(PACKET_BYTES));
    p1_nxt.fill_level  = FILL_W'(count_nxt);
    p1_nxt.dropped     = drop;
    p1_nxt.pop         = pop;
    // Marker written and read at the same entry in the same cycle
    p1_nxt.fwd_dash    = marker_put && (count_r == '0);
    p1_valid_nxt       = accept ? 1'b1 : (p1_go ? 1'b0 : p1_valid_r);
  end

  // Output stage: merge the RAM data and update the shown character
  always_comb begin
    cur_char_nxt = cur_char_r;
    if (p1_go && p1_valid_r && p1_r.pop) begin
      cur_char_nxt = p1_r.fwd_dash ? DASH_CHAR : ram_rdata;
    end
    out_nxt.shown_valid = p1_r.shown_valid;
    out_nxt.shown_char  = cur_char_nxt;
    out_nxt.blink_mode  = p1_r.blink_mode;
    out_nxt.has_room    = p1_r.has_room;
    out_nxt.fill_level  = p1_r.fill_level;
    out_nxt.dropped     = p1_r.dropped;
    out_valid_nxt       = p1_go ? p1_valid_r : out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      marker_r    <= 1'b0;
      fast_r      <= 1'b0;
      mult_r      <= MULT_MIN;
      step_r      <= '0;
      idle_r      <= '0;
      running_r   <= 1'b0;
      cur_char_r  <= DASH_CHAR;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wr_idx_r  <= wr_idx_nxt;
        rd_idx_r  <= rd_idx_nxt;
        count_r   <= count_nxt;
        marker_r  <= marker_nxt;
        fast_r    <= fast_nxt;
        mult_r    <= mult_nxt;
        step_r    <= step_nxt;
        idle_r    <= idle_nxt;
        running_r <= running_nxt;
      end
      cur_char_r  <= cur_char_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r <= p1_nxt;
    end
    if (p1_go && p1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r  <= BASE_PERIOD_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BASE_PERIOD:  base_period_r  <= pwdata[BASE_W-1:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= pwdata[IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[2])
      REG_BASE_PERIOD:  prdata = CFG_DW'(base_period_r);
      REG_IDLE_TIMEOUT: prdata = CFG_DW'(idle_timeout_r);
      default:          prdata = '0;
    endcase
  end

  // Drive the result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.shown_valid = out_r.shown_valid;
  assign out_ch.shown_char  = out_r.shown_char;
  assign out_ch.blink_mode  = out_r.blink_mode;
  assign out_ch.has_room    = out_r.has_room;
  assign out_ch.fill_level  = out_r.fill_level;
  assign out_ch.dropped     = out_r.dropped;

  `DFF_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(FIFO_DEPTH), "fill count above depth")
  `DFF_ASSERT_ALWAYS(a_index_gap, ADDR_W'(wr_idx_r - rd_idx_r) == ADDR_W'(count_r), "index gap")
  `DFF_ASSERT_NEXT(a_pop_tracked, accept && pop, p1_valid_r && p1_r.pop, "pop lost")
  `DFF_ASSERT_IMP(a_mode_steady, out_valid_r && !out_r.shown_valid, out_r.blink_mode == BLINK_STEADY, "blink mode without display step")

endmodule
